// ===== src/gprm_pkg.sv =====
// Package for the guard pattern run matcher: widths, register indexes,
// beat structs and the scorer state type. No dependencies.
package gprm_pkg;
	localparam int MaxRuns = 9;
	localparam int CountW = 13;
	localparam int ColW = 12;
	localparam int IdxW = 4;
	localparam logic [CountW-1:0] CountMax = 13'd8191;

	localparam logic [2:0] REG_WIDTHS = 3'd0;
	localparam logic [2:0] REG_COUNT = 3'd1;
	localparam logic [2:0] REG_AVG = 3'd2;
	localparam logic [2:0] REG_IND = 3'd3;
	localparam logic [2:0] REG_WHITE = 3'd4;

	typedef struct packed {
		logic [CountW-1:0] cnt;
		logic [3:0] w;
	} run_t;

	// snapshot handed from the front part to the scorer
	typedef struct packed {
		run_t [MaxRuns-1:0] runs;
		logic [IdxW-1:0] n;
		logic [ColW-1:0] start;
		logic [ColW-1:0] col;
		logic is_last;
		logic force_nf;
	} job_t;

	typedef struct packed {
		logic found;
		logic [ColW-1:0] start_col;
		logic [ColW-1:0] end_col;
	} res_t;

	typedef enum logic [2:0] {
		SC_IDLE, SC_SUM, SC_DIV, SC_LIM, SC_DEV, SC_AVG, SC_DONE
	} sc_state_t;
endpackage

// ===== src/gprm_front.sv =====
// Front part: run-length counting on the pixel stream.
// Depends on gprm_pkg. Hands a snapshot to the scorer when a score is due.
module gprm_front import gprm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic pixel_black,
	input  logic [ColW-1:0] column,
	input  logic first_of_scan,
	input  logic last_of_row,
	input  logic [35:0] widths,
	input  logic [3:0] pcount,
	input  logic white_first,
	output logic job_valid,
	output job_t job,
	input  logic verdict_valid,
	input  logic verdict_ok
);
	logic [CountW-1:0] cnt_q [MaxRuns];
	logic [IdxW-1:0] idx_q;
	logic ew_q, done_q, wait_q, pend_last_q;
	logic [ColW-1:0] start_q;
	logic [IdxW-1:0] n;
	logic [IdxW-1:0] idx_eff;
	logic ew_eff, done_eff;
	logic [CountW-1:0] cnt_eff [MaxRuns];
	logic [ColW-1:0] start_eff;
	logic fire, close_last, need_score, same_run;
	logic [CountW-1:0] cnt_nx [MaxRuns];
	logic [IdxW-1:0] idx_nx;
	logic ew_nx, done_nx, wait_nx, pend_last_nx;
	logic [ColW-1:0] start_nx;

	assign n = (pcount < 4'd2) ? 4'd2 : ((pcount > 4'(MaxRuns)) ? 4'(MaxRuns) : pcount);
	assign in_ready = !wait_q;
	assign fire = in_valid && in_ready;

	always_comb begin
		for (int i = 0; i < MaxRuns; i++) cnt_eff[i] = first_of_scan ? '0 : cnt_q[i];
		idx_eff = first_of_scan ? '0 : idx_q;
		ew_eff = first_of_scan ? white_first : ew_q;
		done_eff = first_of_scan ? 1'b0 : done_q;
		start_eff = first_of_scan ? column : start_q;
		if (idx_eff >= n) idx_eff = n - 4'd1;
		same_run = pixel_black ^ ew_eff;
		close_last = !same_run && (idx_eff == n - 4'd1);
		need_score = fire && !done_eff && (close_last || last_of_row);
	end

	// snapshot: counts as seen by the score (on row end, after this pixel)
	always_comb begin
		job = '0;
		job.n = n;
		job.col = column;
		job.start = start_eff;
		job.is_last = last_of_row;
		// row end without a closing pixel only matches inside the last run
		job.force_nf = !close_last &&
			(same_run ? (idx_eff != n - 4'd1) : (idx_eff + 4'd1 != n - 4'd1));
		for (int i = 0; i < MaxRuns; i++) begin
			job.runs[i].cnt = cnt_eff[i];
			job.runs[i].w = (i < int'(n)) ? widths[4*i +: 4] : 4'd0;
			if (!close_last && same_run && i == int'(idx_eff) && cnt_eff[i] < CountMax)
				job.runs[i].cnt = cnt_eff[i] + 13'd1;
			if (!close_last && !same_run && i == int'(idx_eff) + 1)
				job.runs[i].cnt = 13'd1;
			if (i >= int'(n)) job.runs[i].cnt = '0;
		end
	end
	assign job_valid = need_score;

	// next state of the run counter
	always_comb begin
		cnt_nx = cnt_q;
		idx_nx = idx_q;
		ew_nx = ew_q;
		done_nx = done_q;
		wait_nx = wait_q;
		pend_last_nx = pend_last_q;
		start_nx = start_q;
		if (wait_q) begin
			if (verdict_valid) begin
				wait_nx = 1'b0;
				if (verdict_ok || pend_last_q) done_nx = 1'b1;
				else begin
					// drop first two runs, open a new last run
					start_nx = start_q + cnt_q[0][ColW-1:0] + cnt_q[1][ColW-1:0];
					for (int i = 0; i < MaxRuns - 2; i++)
						cnt_nx[i] = (i + 2 < int'(n)) ? cnt_q[i+2] : '0;
					cnt_nx[MaxRuns-2] = '0;
					cnt_nx[MaxRuns-1] = '0;
					cnt_nx[n-4'd2] = 13'd1;
					idx_nx = n - 4'd2;
					ew_nx = !ew_q;
				end
			end
		end else if (fire) begin
			cnt_nx = cnt_eff;
			idx_nx = idx_eff;
			ew_nx = ew_eff;
			done_nx = done_eff;
			start_nx = start_eff;
			if (!done_eff) begin
				if (same_run) begin
					if (cnt_eff[idx_eff] < CountMax) cnt_nx[idx_eff] = cnt_eff[idx_eff] + 13'd1;
				end else if (!close_last) begin
					idx_nx = idx_eff + 4'd1;
					cnt_nx[idx_eff + 4'd1] = 13'd1;
					ew_nx = !ew_eff;
				end
				if (need_score) begin
					wait_nx = 1'b1;
					pend_last_nx = last_of_row;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			ew_q <= 1'b0;
			done_q <= 1'b1;
			wait_q <= 1'b0;
			pend_last_q <= 1'b0;
			start_q <= '0;
			for (int i = 0; i < MaxRuns; i++) cnt_q[i] <= '0;
		end else begin
			idx_q <= idx_nx;
			ew_q <= ew_nx;
			done_q <= done_nx;
			wait_q <= wait_nx;
			pend_last_q <= pend_last_nx;
			start_q <= start_nx;
			for (int i = 0; i < MaxRuns; i++) cnt_q[i] <= cnt_nx[i];
		end
	end
endmodule

// ===== src/gprm_fifo.sv =====
// Two-entry queue for score jobs between front and scorer.
// Depends on gprm_pkg.
module gprm_fifo import gprm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	input  job_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output job_t rd_data
);
	job_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && cnt_q != 2'd2;
	assign rd = rd_valid && rd_ready;
	always_ff @(posedge clk) if (wr) mem_q[wp_q] <= wr_data;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end
endmodule

// ===== src/gprm_scorer.sv =====
// Back part: sequential variance scorer, one run per cycle, shift-subtract
// divider for unit and average. Depends on gprm_pkg.
module gprm_scorer import gprm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	output logic job_ready,
	input  job_t job,
	input  logic [8:0] max_avg,
	input  logic [8:0] max_ind,
	output logic verdict_valid,
	output logic verdict_ok,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);
	localparam int TotW = 17;
	localparam int DivW = 25;
	sc_state_t st_q, st_d;
	job_t job_q;
	logic [IdxW-1:0] i_q;
	logic [TotW-1:0] total_q;
	logic [8:0] plen_q;
	logic [DivW-1:0] rem_q, quo_q, dvs_q;
	logic [4:0] bit_q;
	logic [DivW-1:0] unit_q;
	logic [33:0] lim_q;
	logic [DivW+4:0] sum_q;
	logic fail_q, ok_q;
	logic [DivW+4:0] c, s, d;
	logic [DivW-1:0] trial;

	assign job_ready = st_q == SC_IDLE;
	assign c = (DivW+5)'(job_q.runs[i_q].cnt) << 8;
	assign s = (DivW+5)'(job_q.runs[i_q].w) * (DivW+5)'(unit_q);
	assign d = (c > s) ? c - s : s - c;
	assign trial = {rem_q[DivW-2:0], quo_q[DivW-1]};

	always_comb begin
		st_d = st_q;
		case (st_q)
			SC_IDLE: if (job_valid) st_d = SC_SUM;
			SC_SUM: if (i_q == job_q.n - 4'd1) st_d = SC_DIV;
			SC_DIV: begin
				if (fail_q) st_d = SC_DONE;
				else if (bit_q == 5'd0) st_d = SC_LIM;
			end
			SC_LIM: st_d = SC_DEV;
			SC_DEV: if (fail_q || i_q == job_q.n - 4'd1) st_d = SC_AVG;
			SC_AVG: if (fail_q || bit_q == 5'd0) st_d = SC_DONE;
			SC_DONE: if (!res_valid || res_ready) st_d = SC_IDLE;
			default: st_d = SC_IDLE;
		endcase
	end

	always_comb begin
		verdict_valid = (st_q == SC_DONE) && (!res_valid || res_ready);
		verdict_ok = ok_q;
	end

	always_ff @(posedge clk) begin
		case (st_q)
			SC_IDLE: begin
				job_q <= job;
				i_q <= '0;
				total_q <= '0;
				plen_q <= '0;
				fail_q <= 1'b0;
				ok_q <= 1'b0;
			end
			SC_SUM: begin
				total_q <= total_q + TotW'(job_q.runs[i_q].cnt);
				plen_q <= plen_q + 9'(job_q.runs[i_q].w);
				i_q <= i_q + 4'd1;
				quo_q <= DivW'(total_q + TotW'(job_q.runs[i_q].cnt)) << 8;
				rem_q <= '0;
				bit_q <= 5'(DivW - 1);
			end
			SC_DIV: begin
				if (bit_q == 5'(DivW - 1) && (plen_q == 0 || total_q < TotW'(plen_q)))
					fail_q <= 1'b1;
				if (trial >= DivW'(plen_q)) begin
					rem_q <= trial - DivW'(plen_q);
					quo_q <= {quo_q[DivW-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					quo_q <= {quo_q[DivW-2:0], 1'b0};
				end
				bit_q <= bit_q - 5'd1;
			end
			SC_LIM: begin
				unit_q <= quo_q;
				lim_q <= (34'(max_ind) * 34'(quo_q)) >> 8;
				i_q <= '0;
				sum_q <= '0;
			end
			SC_DEV: begin
				if (34'(d) > lim_q) fail_q <= 1'b1;
				sum_q <= sum_q + d;
				i_q <= i_q + 4'd1;
				quo_q <= '0;
				rem_q <= '0;
				dvs_q <= DivW'(total_q);
				bit_q <= 5'd29;
			end
			SC_AVG: begin
				// quotient bits of sum/total accumulate in quo_q
				if ({rem_q[DivW-2:0], sum_q[bit_q]} >= dvs_q) begin
					rem_q <= {rem_q[DivW-2:0], sum_q[bit_q]} - dvs_q;
					quo_q <= {quo_q[DivW-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[DivW-2:0], sum_q[bit_q]};
					quo_q <= {quo_q[DivW-2:0], 1'b0};
				end
				bit_q <= bit_q - 5'd1;
				if (!fail_q && bit_q == 5'd0)
					ok_q <= {quo_q[DivW-2:0], ({rem_q[DivW-2:0], sum_q[0]} >= dvs_q)}
						< DivW'(max_avg);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= SC_IDLE;
			res_valid <= 1'b0;
		end else begin
			st_q <= st_d;
			res_valid <= (verdict_valid && (ok_q || job_q.is_last)) ||
				(res_valid && !res_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (verdict_valid) begin
			res.found <= ok_q && !job_q.force_nf;
			res.start_col <= (ok_q && !job_q.force_nf) ? job_q.start : '0;
			res.end_col <= job_q.col;
		end
	end
endmodule

// ===== src/guard_pattern_run_matcher_core.sv =====
// Top level of the guard pattern run matcher: config registers, front,
// job queue and scorer. Depends on gprm_pkg, gprm_front, gprm_fifo, gprm_scorer.
//
// Usage:
//  - s_axis: one pixel per beat. tdata = pixel_black, column[11:0];
//    tuser = first_of_scan, last_of_row.
//  - m_axis: zero or one result per scan. tdata = found, start_col, end_col.
//  - cfg: index/data write channel, always ready.
// Throughput: one pixel a cycle while runs are counted. When the last run
// of the pattern closes, or the row ends, input stalls while the scorer
// works: the job passes through the queue, the runs are summed and divided
// down to the unit width, the limit is set, the deviations are checked, the
// average is divided out and the verdict is handed over (sooner on a fail).
// Reset: registers take their documented defaults, the block idles until a
// beat with first_of_scan. A stalled m_axis holds the scorer, which holds
// the front through its pending score.
module guard_pattern_run_matcher_core import gprm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // pixel_black, column[11:0]
	input  logic [1:0] s_axis_tuser,    // first_of_scan, last_of_row
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [31:0] m_axis_tdata,   // found, start_col, end_col
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [35:0] cfg_data
);
	logic [35:0] widths_q;
	logic [3:0] pcount_q;
	logic [8:0] avg_q, ind_q;
	logic white_q;
	logic jv, jr, fv, vv, vok;
	job_t job, fjob;
	res_t res;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			widths_q <= 36'd823202072;
			pcount_q <= 4'd8;
			avg_q <= 9'd107;
			ind_q <= 9'd204;
			white_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WIDTHS: widths_q <= cfg_data;
				REG_COUNT: pcount_q <= cfg_data[3:0];
				REG_AVG: avg_q <= cfg_data[8:0];
				REG_IND: ind_q <= cfg_data[8:0];
				REG_WHITE: white_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	gprm_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.pixel_black(s_axis_tdata[0]), .column(s_axis_tdata[12:1]),
		.first_of_scan(s_axis_tuser[0]), .last_of_row(s_axis_tuser[1]),
		.widths(widths_q), .pcount(pcount_q), .white_first(white_q),
		.job_valid(jv), .job(job),
		.verdict_valid(vv), .verdict_ok(vok)
	);

	gprm_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(jv), .wr_data(job),
		.rd_valid(fv), .rd_ready(jr), .rd_data(fjob)
	);

	gprm_scorer u_scorer (
		.clk(clk), .arst_n(arst_n),
		.job_valid(fv), .job_ready(jr), .job(fjob),
		.max_avg(avg_q), .max_ind(ind_q),
		.verdict_valid(vv), .verdict_ok(vok),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
	);

	assign m_axis_tdata = {7'd0, res.end_col, res.start_col, res.found};

	// a verdict only comes while the front is stalled on a pending score
	a_no_pixel_while_scoring: assert property (@(posedge clk) disable iff (!arst_n)
		vv |-> !s_axis_tready) else $error("pixel taken during scoring");
	a_job_stalls_front: assert property (@(posedge clk) disable iff (!arst_n)
		jv |=> !s_axis_tready) else $error("front not stalled after job");
	a_notfound_zero_start: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !res.found) |-> res.start_col == '0)
		else $error("start column set on not found");
endmodule
